// ===== hw/rtl/open_addressing_hash_table_macros.svh =====
// Assertion helpers used by the checker.
`ifndef OPEN_ADDRESSING_HASH_TABLE_MACROS_SVH
`define OPEN_ADDRESSING_HASH_TABLE_MACROS_SVH

// same-cycle implication
`define OAHT_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define OAHT_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== hw/rtl/oaht_pkg.sv =====
package oaht_pkg;

   localparam logic [1:0] OP_SEARCH = 2'd0;
   localparam logic [1:0] OP_INSERT = 2'd1;
   localparam logic [1:0] OP_DELETE = 2'd2;

   localparam logic [2:0] RSP_NOT_FOUND = 3'd0;
   localparam logic [2:0] RSP_FOUND     = 3'd1;
   localparam logic [2:0] RSP_INSERTED  = 3'd2;
   localparam logic [2:0] RSP_UPDATED   = 3'd3;
   localparam logic [2:0] RSP_DELETED   = 3'd4;
   localparam logic [2:0] RSP_FULL      = 3'd5;

   localparam logic [1:0] SLOT_EMPTY = 2'd0;
   localparam logic [1:0] SLOT_USED  = 2'd1;
   localparam logic [1:0] SLOT_TOMB  = 2'd2;

   localparam logic [1:0] PROBE_LINEAR = 2'd0;
   localparam logic [1:0] PROBE_QUAD   = 2'd1;
   localparam logic [1:0] PROBE_DOUBLE = 2'd2;

   localparam logic [1:0] CSR_SLOTS_IN_USE = 2'd0;
   localparam logic [1:0] CSR_PROBE_MODE   = 2'd1;

   localparam logic [2:0] DH_PRIME = 3'd7;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DIV,
      ST_STEP,
      ST_READ,
      ST_CHECK,
      ST_FIN
   } state_type;

   typedef struct packed {
      logic       stat_we;
      logic [1:0] stat_wd;
      logic       key_we;
      logic       data_we;
   } mem_ctl_type;

endpackage

// ===== hw/rtl/open_addressing_hash_table.sv =====
// A request first reduces the key to its home-slot remainder (one key bit a
// cycle), then reduces the probe step below the slot count, then probes, each
// probe a memory read and a compare, and ends in the result register. A new
// request is taken only once the block is idle again; unused op codes skip the
// table and go straight to the result.
// After reset, all CAPACITY slot status entries are cleared with req_ready low;
// configuration resets to slots_in_use = CAPACITY, linear probing.
module open_addressing_hash_table import oaht_pkg::*; #(
   parameter int CAPACITY = 1024,
   parameter int KEY_BITS = 32,
   localparam int AW      = $clog2(CAPACITY)
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [1:0]          req_op,
   input  logic [KEY_BITS-1:0] req_lookup_key,
   input  logic [31:0]         req_data_value,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [2:0]          rsp_status,
   output logic [31:0]         rsp_read_value,
   output logic [AW-1:0]       rsp_slot_index,
   output logic [AW:0]         rsp_occupancy,
   input  logic                csr_write_en,
   input  logic [1:0]          csr_index,
   input  logic [AW:0]         csr_write_data
);

   logic [AW:0]   size_ff, size_in;
   logic [1:0]    mode_ff, mode_in;
   logic          rvld_ff, rvld_in;
   logic [2:0]    rstat_ff;
   logic [31:0]   rval_ff;
   logic [AW-1:0] rslot_ff;
   logic [AW:0]   rocc_ff;

   logic          done;
   logic [2:0]    res_status;
   logic [31:0]   res_value;
   logic [AW-1:0] res_slot;
   logic [AW:0]   res_count;
   logic          out_busy;

   assign out_busy = rvld_ff && !rsp_ready;

   oaht_ctrl #(.CAPACITY(CAPACITY), .KEY_BITS(KEY_BITS), .AW(AW)) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (req_valid && req_ready),
      .op         (req_op),
      .lookup_key (req_lookup_key),
      .data_value (req_data_value),
      .cfg_size   (size_ff),
      .cfg_mode   (mode_ff),
      .out_busy   (out_busy),
      .ready      (req_ready),
      .done       (done),
      .res_status (res_status),
      .res_value  (res_value),
      .res_slot   (res_slot),
      .res_count  (res_count)
   );

   always_comb begin
      size_in = size_ff;
      mode_in = mode_ff;
      if (csr_write_en) begin
         case (csr_index)
            CSR_SLOTS_IN_USE: size_in = csr_write_data;
            CSR_PROBE_MODE:   mode_in = csr_write_data[1:0];
            default: begin
            end
         endcase
      end
      rvld_in = rvld_ff;
      if (done) begin
         rvld_in = 1'b1;
      end else if (rsp_ready) begin
         rvld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= (AW+1)'(CAPACITY);
         mode_ff <= PROBE_LINEAR;
         rvld_ff <= 1'b0;
      end else begin
         size_ff <= size_in;
         mode_ff <= mode_in;
         rvld_ff <= rvld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (done) begin
         rstat_ff <= res_status;
         rval_ff  <= res_value;
         rslot_ff <= res_slot;
         rocc_ff  <= res_count;
      end
   end

   assign rsp_valid      = rvld_ff;
   assign rsp_status     = rstat_ff;
   assign rsp_read_value = rval_ff;
   assign rsp_slot_index = rslot_ff;
   assign rsp_occupancy  = rocc_ff;

endmodule

// ===== hw/rtl/oaht_modunit.sv =====
// (a + b + cin) mod size, for a, b below size
module oaht_modunit import oaht_pkg::*; #(
   parameter int AW = 10
) (
   input  logic [AW-1:0] a,
   input  logic [AW-1:0] b,
   input  logic          cin,
   input  logic [AW:0]   size,
   output logic [AW-1:0] sum_mod
);

   logic [AW+1:0] sum;
   logic [AW+1:0] diff;

   always_comb begin
      sum  = {2'b00, a} + {2'b00, b} + {{(AW+1){1'b0}}, cin};
      diff = sum - {1'b0, size};
      if (sum >= {1'b0, size}) begin
         sum_mod = diff[AW-1:0];
      end else begin
         sum_mod = sum[AW-1:0];
      end
   end

endmodule

// ===== hw/rtl/oaht_store.sv =====
module oaht_store import oaht_pkg::*; #(
   parameter int CAPACITY = 1024,
   parameter int KEY_BITS = 32,
   parameter int AW       = 10
) (
   input  logic                clock,
   input  mem_ctl_type         ctl,
   input  logic [AW-1:0]       wr_addr,
   input  logic [KEY_BITS-1:0] wr_key,
   input  logic [31:0]         wr_data,
   input  logic [AW-1:0]       rd_addr,
   output logic [1:0]          rd_stat,
   output logic [KEY_BITS-1:0] rd_key,
   output logic [31:0]         rd_data
);

   logic [1:0]          stat_mem [CAPACITY];
   logic [KEY_BITS-1:0] key_mem  [CAPACITY];
   logic [31:0]         data_mem [CAPACITY];

   always_ff @(posedge clock) begin
      if (ctl.stat_we) begin
         stat_mem[wr_addr] <= ctl.stat_wd;
      end
      if (ctl.key_we) begin
         key_mem[wr_addr] <= wr_key;
      end
      if (ctl.data_we) begin
         data_mem[wr_addr] <= wr_data;
      end
      rd_stat <= stat_mem[rd_addr];
      rd_key  <= key_mem[rd_addr];
      rd_data <= data_mem[rd_addr];
   end

endmodule

// ===== hw/rtl/oaht_ctrl.sv =====
module oaht_ctrl import oaht_pkg::*; #(
   parameter int CAPACITY = 1024,
   parameter int KEY_BITS = 32,
   parameter int AW       = 10
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [1:0]          op,
   input  logic [KEY_BITS-1:0] lookup_key,
   input  logic [31:0]         data_value,
   input  logic [AW:0]         cfg_size,
   input  logic [1:0]          cfg_mode,
   input  logic                out_busy,
   output logic                ready,
   output logic                done,
   output logic [2:0]          res_status,
   output logic [31:0]         res_value,
   output logic [AW-1:0]       res_slot,
   output logic [AW:0]         res_count
);

   localparam int BW = $clog2(KEY_BITS);

   state_type           state_ff, state_in;
   logic [1:0]          op_ff, op_in;
   logic [KEY_BITS-1:0] key_ff, key_in;
   logic [31:0]         data_ff, data_in;
   logic [AW:0]         size_ff, size_in;
   logic [1:0]          mode_ff, mode_in;
   logic [BW-1:0]       bit_ff, bit_in;
   logic [2:0]          r7_ff, r7_in;
   logic [AW-1:0]       pos_ff, pos_in;
   logic [AW:0]         inc_ff, inc_in;
   logic [AW:0]         probe_ff, probe_in;
   logic                tvld_ff, tvld_in;
   logic [AW-1:0]       tomb_ff, tomb_in;
   logic [AW-1:0]       clr_ff, clr_in;
   logic [AW:0]         count_ff, count_in;
   logic [2:0]          rst_ff, rst_in;
   logic [31:0]         rval_ff, rval_in;
   logic [AW-1:0]       rslot_ff, rslot_in;

   mem_ctl_type         mctl;
   logic [AW-1:0]       wr_addr;
   logic [1:0]          rd_stat;
   logic [KEY_BITS-1:0] rd_key;
   logic [31:0]         rd_data;

   logic                mu_cin;
   logic [AW-1:0]       mu_b;
   logic [AW-1:0]       mu_out;

   logic [3:0]          r7_t;
   logic [2:0]          r7_next;
   logic [AW+1:0]       q1, q2;
   logic                last_probe;
   logic                hit;
   logic                is_tomb;
   logic [AW-1:0]       t_addr;
   logic                have_t;
   logic                check_end;

   oaht_modunit #(.AW(AW)) u_mod (
      .a       (pos_ff),
      .b       (mu_b),
      .cin     (mu_cin),
      .size    (size_ff),
      .sum_mod (mu_out)
   );

   oaht_store #(.CAPACITY(CAPACITY), .KEY_BITS(KEY_BITS), .AW(AW)) u_store (
      .clock   (clock),
      .ctl     (mctl),
      .wr_addr (wr_addr),
      .wr_key  (key_ff),
      .wr_data (data_ff),
      .rd_addr (pos_ff),
      .rd_stat (rd_stat),
      .rd_key  (rd_key),
      .rd_data (rd_data)
   );

   always_comb begin
      // remainder step shares the unit: r = 2r + bit
      mu_cin = (state_ff == ST_DIV) ? key_ff[bit_ff] : 1'b0;
      mu_b   = (state_ff == ST_DIV) ? pos_ff : inc_ff[AW-1:0];
      r7_t   = {r7_ff, mu_cin};
      r7_next = (r7_t >= {1'b0, DH_PRIME}) ? 3'(r7_t - {1'b0, DH_PRIME}) : r7_t[2:0];
      q1 = {1'b0, inc_ff} + (AW+2)'(2);
      if (q1 >= {1'b0, size_ff}) begin
         q1 = q1 - {1'b0, size_ff};
      end
      q2 = q1;
      if (q2 >= {1'b0, size_ff}) begin
         q2 = q2 - {1'b0, size_ff};
      end
      last_probe = (probe_ff == size_ff - (AW+1)'(1));
      hit        = (rd_stat == SLOT_USED) && (rd_key == key_ff);
      is_tomb    = (rd_stat == SLOT_TOMB);
      have_t     = tvld_ff || is_tomb;
      t_addr     = tvld_ff ? tomb_ff : pos_ff;
      check_end  = (rd_stat == SLOT_EMPTY) || hit || last_probe;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == AW'(CAPACITY - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               if (op == OP_SEARCH || op == OP_INSERT || op == OP_DELETE) begin
                  state_in = ST_DIV;
               end else begin
                  state_in = ST_FIN;
               end
            end
         end
         ST_DIV: begin
            if (bit_ff == '0) begin
               state_in = ST_STEP;
            end
         end
         ST_STEP: begin
            if (inc_ff < size_ff) begin
               state_in = ST_READ;
            end
         end
         ST_READ:  state_in = ST_CHECK;
         ST_CHECK: state_in = check_end ? ST_FIN : ST_READ;
         ST_FIN: begin
            if (!out_busy) begin
               state_in = ST_IDLE;
            end
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   // datapath and memory control
   always_comb begin
      op_in    = op_ff;
      key_in   = key_ff;
      data_in  = data_ff;
      size_in  = size_ff;
      mode_in  = mode_ff;
      bit_in   = bit_ff;
      r7_in    = r7_ff;
      pos_in   = pos_ff;
      inc_in   = inc_ff;
      probe_in = probe_ff;
      tvld_in  = tvld_ff;
      tomb_in  = tomb_ff;
      clr_in   = clr_ff;
      count_in = count_ff;
      rst_in   = rst_ff;
      rval_in  = rval_ff;
      rslot_in = rslot_ff;
      mctl     = '0;
      wr_addr  = pos_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            mctl.stat_we = 1'b1;
            mctl.stat_wd = SLOT_EMPTY;
            wr_addr      = clr_ff;
            clr_in       = clr_ff + AW'(1);
         end
         ST_IDLE: begin
            if (start) begin
               op_in   = op;
               key_in  = lookup_key;
               data_in = data_value;
               if (cfg_size == '0) begin
                  size_in = (AW+1)'(1);
               end else if (cfg_size > (AW+1)'(CAPACITY)) begin
                  size_in = (AW+1)'(CAPACITY);
               end else begin
                  size_in = cfg_size;
               end
               mode_in  = (cfg_mode == PROBE_QUAD || cfg_mode == PROBE_DOUBLE) ?
                          cfg_mode : PROBE_LINEAR;
               bit_in   = BW'(KEY_BITS - 1);
               r7_in    = '0;
               pos_in   = '0;
               probe_in = '0;
               tvld_in  = 1'b0;
               rst_in   = RSP_NOT_FOUND;
               rval_in  = '0;
               rslot_in = '0;
            end
         end
         ST_DIV: begin
            pos_in = mu_out;
            r7_in  = r7_next;
            bit_in = bit_ff - BW'(1);
            if (mode_ff == PROBE_DOUBLE) begin
               inc_in = (AW+1)'(DH_PRIME - r7_next);
            end else begin
               inc_in = (AW+1)'(1);
            end
         end
         ST_STEP: begin
            if (inc_ff >= size_ff) begin
               inc_in = inc_ff - size_ff;
            end
         end
         ST_READ: begin
         end
         ST_CHECK: begin
            if (op_ff == OP_INSERT) begin
               if (rd_stat == SLOT_EMPTY || (last_probe && !hit && have_t)) begin
                  mctl.stat_we = 1'b1;
                  mctl.stat_wd = SLOT_USED;
                  mctl.key_we  = 1'b1;
                  mctl.data_we = 1'b1;
                  wr_addr      = t_addr;
                  count_in     = count_ff + (AW+1)'(1);
                  rst_in       = RSP_INSERTED;
                  rslot_in     = t_addr;
               end else if (hit) begin
                  mctl.data_we = 1'b1;
                  rst_in       = RSP_UPDATED;
                  rslot_in     = pos_ff;
               end else if (last_probe) begin
                  rst_in = RSP_FULL;
               end
               if (is_tomb && !tvld_ff) begin
                  tvld_in = 1'b1;
                  tomb_in = pos_ff;
               end
            end else if (hit) begin
               rslot_in = pos_ff;
               if (op_ff == OP_SEARCH) begin
                  rst_in  = RSP_FOUND;
                  rval_in = rd_data;
               end else begin
                  mctl.stat_we = 1'b1;
                  mctl.stat_wd = SLOT_TOMB;
                  rst_in       = RSP_DELETED;
                  if (count_ff != '0) begin
                     count_in = count_ff - (AW+1)'(1);
                  end
               end
            end
            pos_in   = mu_out;
            probe_in = probe_ff + (AW+1)'(1);
            if (mode_ff == PROBE_QUAD) begin
               inc_in = q2[AW:0];
            end
         end
         ST_FIN: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff    <= op_in;
      key_ff   <= key_in;
      data_ff  <= data_in;
      size_ff  <= size_in;
      mode_ff  <= mode_in;
      bit_ff   <= bit_in;
      r7_ff    <= r7_in;
      pos_ff   <= pos_in;
      inc_ff   <= inc_in;
      probe_ff <= probe_in;
      tvld_ff  <= tvld_in;
      tomb_ff  <= tomb_in;
      rst_ff   <= rst_in;
      rval_ff  <= rval_in;
      rslot_ff <= rslot_in;
   end

   assign ready      = (state_ff == ST_IDLE);
   assign done       = (state_ff == ST_FIN) && !out_busy;
   assign res_status = rst_ff;
   assign res_value  = rval_ff;
   assign res_slot   = rslot_ff;
   assign res_count  = count_ff;

endmodule

// ===== hw/rtl/oaht_checker.sv =====
`include "open_addressing_hash_table_macros.svh"

module oaht_checker import oaht_pkg::*; #(
   parameter int CAPACITY = 1024,
   localparam int AW      = $clog2(CAPACITY)
) (
   input logic                clock,
   input logic                reset,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic [2:0]          rsp_status,
   input logic [31:0]         rsp_read_value,
   input logic [AW-1:0]       rsp_slot_index,
   input logic [AW:0]         rsp_occupancy
);

   `OAHT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_status) && $stable(rsp_slot_index))
   `OAHT_ASSERT_NOW(a_value_only_found, clock, reset,
      rsp_valid && rsp_status != RSP_FOUND, rsp_read_value == '0)
   `OAHT_ASSERT_NOW(a_no_slot_on_miss, clock, reset,
      rsp_valid && (rsp_status == RSP_NOT_FOUND || rsp_status == RSP_FULL),
      rsp_slot_index == '0)
   `OAHT_ASSERT_NOW(a_occ_bound, clock, reset, rsp_valid,
      rsp_occupancy <= (AW+1)'(CAPACITY))

endmodule

bind open_addressing_hash_table oaht_checker #(
   .CAPACITY(CAPACITY)
) u_oaht_checker (.*);
